### rtl/qsa_pkg.sv
// Shared types and constants for the quarantine slot allocator.
package qsa_pkg;

  parameter int unsigned SLOTS_DEFAULT = 16;

  // Width of the reserved, committed and holder counts, and of each stream word.
  parameter int unsigned CNT_W    = 8;
  parameter int unsigned IN_DW    = 16;
  parameter int unsigned OUT_DW   = 32;
  parameter int unsigned GRANT_W  = 7;

  typedef enum logic [2:0] {
    OP_RESERVE  = 3'd0,
    OP_RELEASE  = 3'd1,
    OP_COMMIT   = 3'd2,
    OP_SET_FUSE = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_QUERY    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_RESERVED  = 2'd1,
    SLOT_COMMITTED = 2'd2
  } slot_state_e;

  typedef struct packed {
    slot_state_e state;
    logic        holds;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOOKUP,
    ST_DONE
  } fsm_state_e;

endpackage

### rtl/quarantine_slot_allocator_unit.sv
// Quarantine slot allocator: slot table in a synchronous memory with a latching fuse.
//
//   Channel   Dir   Bits  Contents (lowest bit first)
//   s_axis    in    16    op[2:0], slot_index[10:3], holds_resource[11], zeros
//   m_axis    out   32    ok[0], granted_slot[7:1], fuse_latched[8],
//                         reserved_total[16:9], committed_total[24:17], table_full[25], zeros
//
// A reserve scans the slot memory from slot 0 through the single read port, one
// entry per cycle. Release and commit read and rewrite one entry. One word is
// in flight at a time. The result sits in an output register, so a stalled
// output only holds the block once a second result is ready. Reset is
// immediate: a valid bit per slot makes every slot read as Free, and clear drops
// all valid bits at once.
module quarantine_slot_allocator_unit import qsa_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // op[2:0], slot_index[10:3], holds_resource[11], zero fill [15:12]
  input  logic [IN_DW-1:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // ok[0], granted_slot[7:1], fuse_latched[8], reserved_total[16:9],
  // committed_total[24:17], table_full[25], zero fill [31:26]
  output logic [OUT_DW-1:0] m_axis_tdata
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // The scan counter must be able to hold SLOTS itself.
  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SlotsCnt  = CNT_W'(SLOTS);
  localparam logic [SW-1:0]    SlotsScan = SW'(SLOTS);

  // Fields of the incoming word.
  op_e        op_in;
  logic [7:0] slot_index_in;
  logic       holds_in;

  assign op_in         = op_e'(s_axis_tdata[2:0]);
  assign slot_index_in = s_axis_tdata[10:3];
  assign holds_in      = s_axis_tdata[11];

  fsm_state_e        state_q, state_d;
  op_e               op_q;
  logic              holds_q;
  logic [SW-1:0]     scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     raddr_q, raddr_d;
  logic              ok_q, ok_d;
  logic [AW-1:0]     grant_q, grant_d;
  logic              fuse_q, fuse_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic [CNT_W-1:0]  com_cnt_q, com_cnt_d;
  // Committed slots that hold a resource; clear is refused while nonzero.
  logic [CNT_W-1:0]  held_cnt_q, held_cnt_d;
  logic [SLOTS-1:0]  vld_q, vld_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_DW-1:0] out_data_q, out_data_d;

  // Slot memory and its ports.
  slot_entry_t       slot_mem_q [SLOTS];
  slot_entry_t       rd_data_q;
  logic              rd_vld_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  slot_entry_t       wr_data;
  logic              accept;
  logic              entry_free;
  logic              entry_reserved;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // An entry whose valid bit is clear has been freed by reset or clear.
  assign entry_free     = !rd_vld_q || (rd_data_q.state == SLOT_FREE);
  assign entry_reserved = rd_vld_q && (rd_data_q.state == SLOT_RESERVED);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= slot_mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_in;
      holds_q <= holds_in;
    end
    raddr_q    <= raddr_d;
    grant_q    <= grant_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      ok_q        <= 1'b0;
      fuse_q      <= 1'b0;
      res_cnt_q   <= '0;
      com_cnt_q   <= '0;
      held_cnt_q  <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      ok_q        <= ok_d;
      fuse_q      <= fuse_d;
      res_cnt_q   <= res_cnt_d;
      com_cnt_q   <= com_cnt_d;
      held_cnt_q  <= held_cnt_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    raddr_d     = raddr_q;
    ok_d        = ok_q;
    grant_d     = grant_q;
    fuse_d      = fuse_q;
    res_cnt_d   = res_cnt_q;
    com_cnt_d   = com_cnt_q;
    held_cnt_d  = held_cnt_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = raddr_q;
    wr_data     = '{state: SLOT_FREE, holds: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          ok_d    = 1'b0;
          grant_d = '0;
          raddr_d = slot_index_in[AW-1:0];
          state_d = ST_DONE;
          case (op_in) inside
            OP_RESERVE: begin
              // The reserved count equals the number of slots in use, so a free
              // slot exists whenever it is below SLOTS and the scan always ends.
              if (!fuse_q && (res_cnt_q < SlotsCnt)) begin
                scan_d  = '0;
                pend_d  = 1'b0;
                state_d = ST_SCAN;
              end
            end
            OP_RELEASE, OP_COMMIT: begin
              if (op_in == OP_COMMIT) begin
                fuse_d = 1'b1;
              end
              if (slot_index_in < SlotsCnt) begin
                rd_en   = 1'b1;
                rd_addr = slot_index_in[AW-1:0];
                state_d = ST_LOOKUP;
              end
            end
            OP_SET_FUSE: begin
              fuse_d = 1'b1;
            end
            OP_CLEAR: begin
              if (held_cnt_q == '0) begin
                vld_d      = '0;
                res_cnt_d  = '0;
                com_cnt_d  = '0;
                held_cnt_d = '0;
                fuse_d     = 1'b0;
                ok_d       = 1'b1;
              end
            end
            default: begin
              // Query and the unused codes change nothing.
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next address while checking the entry read last cycle.
        if (scan_q < SlotsScan) begin
          rd_en   = 1'b1;
          rd_addr = scan_q[AW-1:0];
        end
        pend_d  = (scan_q < SlotsScan);
        raddr_d = scan_q[AW-1:0];
        scan_d  = scan_q + SW'(1);
        if (pend_q && entry_free) begin
          wr_en          = 1'b1;
          wr_addr        = raddr_q;
          wr_data        = '{state: SLOT_RESERVED, holds: 1'b0};
          vld_d[raddr_q] = 1'b1;
          res_cnt_d      = res_cnt_q + CNT_W'(1);
          ok_d           = 1'b1;
          grant_d        = raddr_q;
          raddr_d        = raddr_q;
          state_d        = ST_DONE;
        end
      end

      ST_LOOKUP: begin
        if (entry_reserved) begin
          wr_en          = 1'b1;
          wr_addr        = raddr_q;
          vld_d[raddr_q] = 1'b1;
          ok_d           = 1'b1;
          if (op_q == OP_RELEASE) begin
            wr_data = '{state: SLOT_FREE, holds: 1'b0};
            if (res_cnt_q != '0) begin
              res_cnt_d = res_cnt_q - CNT_W'(1);
            end
          end else begin
            wr_data    = '{state: SLOT_COMMITTED, holds: holds_q};
            com_cnt_d  = com_cnt_q + CNT_W'(1);
            held_cnt_d = held_cnt_q + CNT_W'(holds_q);
          end
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {(OUT_DW - 26)'(0), (res_cnt_q >= SlotsCnt), com_cnt_q, res_cnt_q,
                         fuse_q, GRANT_W'(grant_q), ok_q};
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### tb/quarantine_slot_allocator_unit_test.sv
// Stream-level self-checking testbench for the quarantine slot allocator.
`timescale 1ns / 100ps

module quarantine_slot_allocator_unit_test;
  import qsa_pkg::*;

  localparam int unsigned SLOTS      = SLOTS_DEFAULT;
  localparam int unsigned ITEM_GOAL  = 2000;
  localparam int unsigned CALM_TAIL  = 200;
  localparam int unsigned DRAIN      = 2 * SLOTS + 20;
  localparam int unsigned CYCLE_CAP  = 400000;

  // Op codes outside the defined set; the block treats them as a query.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [7:0] slot_index;
    logic       holds;
  } word_t;

  typedef struct {
    logic               ok;
    logic [GRANT_W-1:0] granted;
    logic               fuse;
    logic [CNT_W-1:0]   reserved;
    logic [CNT_W-1:0]   committed;
    logic               full;
  } status_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // op[2:0], slot_index[10:3], holds_resource[11], zero fill [15:12]
  logic [IN_DW-1:0]  s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // ok[0], granted_slot[7:1], fuse_latched[8], reserved_total[16:9],
  // committed_total[24:17], table_full[25], zero fill [31:26]
  logic [OUT_DW-1:0] m_axis_tdata;

  quarantine_slot_allocator_unit #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the slot table.
  slot_state_e      slot_state_q [SLOTS];
  logic             slot_holds_q [SLOTS];
  logic [CNT_W-1:0] reserved_q;
  logic [CNT_W-1:0] committed_q;
  logic             fuse_q;

  word_t   op_backlog_q [$];
  status_t status_due_q [$];
  word_t   cur_word;
  status_t seen;
  status_t due;
  status_t fresh;
  bit      word_taken;
  bit      drive_valid;
  bit      drive_ready;
  int      in_gap;
  int      out_stall;
  int      errors;
  int      cycles;

  task automatic wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_state_q[i] = SLOT_FREE;
      slot_holds_q[i] = 1'b0;
    end
    reserved_q  = '0;
    committed_q = '0;
    fuse_q      = 1'b0;
  endtask

  task automatic advance_slot_table(input word_t w, output status_t s);
    logic blocked;
    logic found;
    s = '{default: '0};
    blocked = 1'b0;
    found = 1'b0;
    case (w.op)
      OP_RESERVE: begin
        if (!fuse_q) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_state_q[i] == SLOT_FREE) begin
              slot_state_q[i] = SLOT_RESERVED;
              slot_holds_q[i] = 1'b0;
              reserved_q      = reserved_q + 1'b1;
              s.granted       = i[GRANT_W-1:0];
              s.ok            = 1'b1;
              found           = 1'b1;
            end
          end
        end
      end
      OP_RELEASE: begin
        if (w.slot_index < SLOTS && slot_state_q[w.slot_index] == SLOT_RESERVED) begin
          slot_state_q[w.slot_index] = SLOT_FREE;
          slot_holds_q[w.slot_index] = 1'b0;
          if (reserved_q > 0) reserved_q = reserved_q - 1'b1;
          s.ok = 1'b1;
        end
      end
      OP_COMMIT: begin
        fuse_q = 1'b1;
        if (w.slot_index < SLOTS && slot_state_q[w.slot_index] == SLOT_RESERVED) begin
          slot_state_q[w.slot_index] = SLOT_COMMITTED;
          slot_holds_q[w.slot_index] = w.holds;
          committed_q = committed_q + 1'b1;
          s.ok = 1'b1;
        end
      end
      OP_SET_FUSE: fuse_q = 1'b1;
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_state_q[i] == SLOT_COMMITTED && slot_holds_q[i]) blocked = 1'b1;
        end
        if (!blocked) begin
          wipe_table();
          s.ok = 1'b1;
        end
      end
      default: ;
    endcase
    s.fuse      = fuse_q;
    s.reserved  = reserved_q;
    s.committed = committed_q;
    s.full      = (reserved_q >= SLOTS);
  endtask

  task automatic push_word(input logic [2:0] op, input logic [7:0] idx, input logic h);
    word_t w;
    w.op = op;
    w.slot_index = idx;
    w.holds = h;
    op_backlog_q.insert(op_backlog_q.size(), w);
  endtask

  task automatic report_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // A clear, a run of reserves, releases and queries, maybe a commit with a reserve and a release, then another clear.
  task automatic queue_alloc_run();
    int n;
    int r;
    n = $urandom_range(1, 20);
    push_word(OP_CLEAR, 8'($urandom), 1'($urandom));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 6) push_word(OP_RESERVE, 8'($urandom), 1'($urandom));
      else if (r < 9) push_word(OP_RELEASE, 8'($urandom_range(0, SLOTS - 1)), 1'($urandom));
      else push_word(OP_QUERY, 8'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 1) == 1) begin
      // Commits carry no resource here, so the next clear is never refused.
      push_word(OP_COMMIT, 8'($urandom_range(0, SLOTS - 1)), 1'b0);
      push_word(OP_RESERVE, 8'($urandom), 1'($urandom));
      push_word(OP_RELEASE, 8'($urandom_range(0, SLOTS - 1)), 1'($urandom));
    end
    push_word(OP_CLEAR, 8'($urandom), 1'($urandom));
  endtask

  task automatic queue_fill_run();
    push_word(OP_CLEAR, 8'($urandom), 1'($urandom));
    for (int k = 0; k < SLOTS + $urandom_range(0, 3); k++) begin
      push_word(OP_RESERVE, 8'($urandom), 1'($urandom));
    end
    push_word(OP_RELEASE, 8'($urandom_range(0, SLOTS - 1)), 1'($urandom));
    push_word(OP_RESERVE, 8'($urandom), 1'($urandom));
    push_word(OP_COMMIT, 8'($urandom_range(0, SLOTS - 1)), 1'b0);
    push_word(OP_CLEAR, 8'($urandom), 1'($urandom));
  endtask

  task automatic queue_noise();
    logic [2:0] op;
    for (int k = 0; k < 10; k++) begin
      op = 3'($urandom_range(0, 7));
      push_word(op, ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(0, SLOTS)),
                (op == OP_COMMIT) ? 1'b0 : 1'($urandom));
    end
  endtask

  task automatic queue_broken_run();
    push_word(OP_CLEAR, 8'($urandom), 1'($urandom));
    push_word(OP_RELEASE, 8'($urandom), 1'($urandom));
    push_word(OP_COMMIT, 8'($urandom_range(SLOTS, 255)), 1'($urandom));
    push_word(OP_RESERVE, 8'($urandom), 1'($urandom));
    push_word(OP_RELEASE, 8'($urandom_range(0, SLOTS - 1)), 1'($urandom));
    push_word(OP_CLEAR, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    word_taken    = 1'b0;
    in_gap        = 0;
    out_stall     = 0;
    errors        = 0;
    cycles        = 0;
    cur_word      = '{op: OP_QUERY, slot_index: '0, holds: 1'b0};
    wipe_table();

    // Directed opening: each corner of the op set from a fresh table.
    push_word(OP_QUERY,    8'd0,   1'b0);
    push_word(OP_RELEASE,  8'd0,   1'b1);  // nothing reserved yet
    push_word(OP_RESERVE,  8'd0,   1'b0);
    push_word(OP_RESERVE,  8'd255, 1'b1);
    push_word(OP_RELEASE,  8'd1,   1'b0);
    push_word(OP_RELEASE,  8'd1,   1'b0);  // already free
    push_word(OP_RELEASE,  8'd255, 1'b0);  // beyond the table
    push_word(OP_RESERVE,  8'd0,   1'b0);
    push_word(OP_COMMIT,   8'd0,   1'b0);
    push_word(OP_RESERVE,  8'd0,   1'b0);  // refused by the fuse
    push_word(OP_COMMIT,   8'd0,   1'b1);  // already committed
    push_word(OP_COMMIT,   8'd255, 1'b1);  // beyond the table, fuse still set
    push_word(OP_RELEASE,  8'd0,   1'b0);  // committed slots cannot be released
    push_word(OP_SPARE_A,  8'd170, 1'b1);
    push_word(OP_SPARE_B,  8'd85,  1'b0);
    push_word(OP_CLEAR,    8'd0,   1'b0);
    push_word(OP_SET_FUSE, 8'd0,   1'b0);
    push_word(OP_RESERVE,  8'd0,   1'b0);
    push_word(OP_CLEAR,    8'd0,   1'b0);
    push_word(OP_RESERVE,  8'd0,   1'b0);

    while (op_backlog_q.size() < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: queue_alloc_run();
        5:             queue_fill_run();
        6, 7:          queue_noise();
        default:       queue_broken_run();
      endcase
    end

    // A committed slot with a resource pins the table for good, so it comes last.
    push_word(OP_CLEAR,    8'd0, 1'b0);
    push_word(OP_RESERVE,  8'd0, 1'b0);
    push_word(OP_RESERVE,  8'd0, 1'b0);
    push_word(OP_COMMIT,   8'd0, 1'b1);
    push_word(OP_COMMIT,   8'd1, 1'b0);
    push_word(OP_CLEAR,    8'd0, 1'b0);  // refused
    push_word(OP_RELEASE,  8'd1, 1'b0);
    push_word(OP_RESERVE,  8'd0, 1'b0);
    push_word(OP_QUERY,    8'd0, 1'b0);

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_backlog_q.size() > 0 || s_axis_tvalid || status_due_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0 && status_due_q.size() == 0) begin
      $display("** quarantine_slot_allocator_unit: PASSED **");
    end else begin
      $display("** quarantine_slot_allocator_unit: FAILED **");
    end
    $finish;
  end

  // Driver: stimulus and output back-pressure change at the falling edge.
  always @(negedge clk_i) begin
    drive_valid = s_axis_tvalid;
    if (word_taken) begin
      drive_valid = 1'b0;
      word_taken = 1'b0;
    end
    if (rst_ni && !drive_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (op_backlog_q.size() > 0) begin
        if (op_backlog_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 8);
        end else begin
          cur_word = op_backlog_q.pop_front();
          drive_valid = 1'b1;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      drive_ready = 1'b0;
    end else if (rst_ni && op_backlog_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0) begin
      out_stall = $urandom_range(0, 8);
      drive_ready = 1'b0;
    end else begin
      drive_ready = rst_ni;
    end
    s_axis_tvalid <= drive_valid;
    s_axis_tdata  <= {4'b0, cur_word.holds, cur_word.slot_index, cur_word.op};
    m_axis_tready <= drive_ready;
  end

  // Monitor: handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_CAP);
      $display("** quarantine_slot_allocator_unit: FAILED **");
      $finish;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      advance_slot_table(cur_word, fresh);
      status_due_q.insert(status_due_q.size(), fresh);
      word_taken = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.ok        = m_axis_tdata[0];
      seen.granted   = m_axis_tdata[7:1];
      seen.fuse      = m_axis_tdata[8];
      seen.reserved  = m_axis_tdata[16:9];
      seen.committed = m_axis_tdata[24:17];
      seen.full      = m_axis_tdata[25];
      if (status_due_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        due = status_due_q.pop_front();
        report_field("ok", due.ok, seen.ok);
        report_field("granted_slot", due.granted, seen.granted);
        report_field("fuse_latched", due.fuse, seen.fuse);
        report_field("reserved_total", due.reserved, seen.reserved);
        report_field("committed_total", due.committed, seen.committed);
        report_field("table_full", due.full, seen.full);
      end
    end
  end

endmodule

### files.f
rtl/qsa_pkg.sv
rtl/quarantine_slot_allocator_unit.sv
tb/quarantine_slot_allocator_unit_test.sv
